### rtl/assert_macros.svh
// Assertion macros for the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the cycle after it holds.
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rcd_pkg.sv
// Shared types and constants of the RTMP chunk deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcd_pkg;

  localparam int STREAM_W = 17;
  localparam logic [23:0] STAMP_ESCAPE = 24'hFFFFFF;
  localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;
  localparam logic [16:0] ID1_BASE = 17'd64;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BODY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Per chunk stream context kept in the context memory.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] msg_index;
    logic [23:0] msg_len;
    logic [23:0] stamp_field;
    logic [31:0] stamp_time;
    logic [23:0] received;
    logic        absolute;
  } ctx_t;

  // Message header length by fmt.
  function automatic logic [3:0] msg_hdr_len(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      2'd0: n = 4'd11;
      2'd1: n = 4'd7;
      2'd2: n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/rtmp_chunk_deframer.sv
// Top level of the RTMP chunk deframer: header parser, context handling, output register.
// Depends on rcd_pkg, rcd_slot_cam, rcd_ctx_mem and assert_macros.svh.
`timescale 1ns / 1ps

// Channel   Direction  Width  Contents
// in_*      input      8      tdata: data_byte
// out_*     output     128    tdata: payload, stream id, type, index, body size, timestamp
//                             tlast: last_of_message, tuser: status
// cfg_*     input      24     data: chunk_size
//
// One byte is taken per cycle unless the output stalls or a lookup is pending. After
// the byte that completes a basic header, the stream context is read from memory.
// Reset (rst_n low, synchronous) clears the parser, the stream table valid bits and the
// output register; chunk_size returns to 128. The context memory needs no clearing.
// A stalled output holds the input off; an error result halts input until reset.

module rtmp_chunk_deframer
  import rcd_pkg::*;
#(
  parameter int NUM_CONTEXTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [7:0] payload_byte, [24:8] chunk_stream_id,
                                   // [32:25] message_type, [64:33] msg_stream_id,
                                   // [88:65] msg_length, [120:89] timestamp, rest zero
  output logic         out_tlast,  // last_of_message
  output logic [1:0]   out_tuser,  // [1:0] status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data    // chunk_size
);

  `include "assert_macros.svh"

  localparam int SW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  localparam logic [2:0] PH_BASIC   = 3'd0;
  localparam logic [2:0] PH_ID1     = 3'd1;
  localparam logic [2:0] PH_ID2     = 3'd2;
  localparam logic [2:0] PH_MSGHDR  = 3'd3;
  localparam logic [2:0] PH_EXTTS   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_LOOKUP  = 3'd6;

  typedef struct packed {
    logic        err;
    ctx_t        ctx;
    logic [2:0]  phase;
    logic [23:0] cbl;
    logic [31:0] ext;
  } step_t;

  // Resolve a finished header: cut the chunk, complete an empty message, or flag a bad length.
  function automatic step_t after_ext(input ctx_t c, input logic [31:0] e,
                                      input logic [23:0] cs);
    step_t r;
    logic [23:0] rest;
    r.err   = 1'b0;
    r.ctx   = c;
    r.phase = PH_BASIC;
    r.cbl   = '0;
    r.ext   = e;
    rest    = c.msg_len - c.received;
    if (c.msg_len < c.received) begin
      r.err = 1'b1;
    end else if (rest == '0) begin
      r.ctx.stamp_time = e + (c.absolute ? 32'd0 : c.stamp_time);
      r.ctx.received   = '0;
    end else begin
      r.cbl   = (rest < cs) ? rest : cs;
      r.phase = PH_PAYLOAD;
    end
    return r;
  endfunction

  function automatic step_t after_msg(input ctx_t c, input logic [23:0] cs);
    step_t r;
    if (c.stamp_field == STAMP_ESCAPE) begin
      r.err   = 1'b0;
      r.ctx   = c;
      r.phase = PH_EXTTS;
      r.cbl   = '0;
      r.ext   = '0;
    end else begin
      r = after_ext(c, {8'd0, c.stamp_field}, cs);
    end
    return r;
  endfunction

  logic [2:0]          phase_r, phase_nxt;
  logic [3:0]          hbc_r, hbc_nxt;
  logic [1:0]          fmt_r, fmt_nxt;
  logic [STREAM_W-1:0] stream_r, stream_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic                new_r, new_nxt;
  logic [23:0]         cbl_r, cbl_nxt;
  logic [31:0]         ext_r, ext_nxt;
  logic                halted_r, halted_nxt;
  ctx_t                ctx_r, ctx_nxt;
  logic [23:0]         csize_r;
  logic [23:0]         cs_eff;

  logic                out_valid_r;
  logic [127:0]        out_data_r;
  logic                out_last_r;
  logic [1:0]          out_user_r;

  logic                res_valid;
  logic [7:0]          res_byte;
  logic [STREAM_W-1:0] res_stream;
  logic [7:0]          res_type;
  logic [31:0]         res_index;
  logic [23:0]         res_body;
  logic [31:0]         res_stamp;
  logic                res_last;
  logic [1:0]          res_status;

  logic                out_free, acc, lk_go, begin_chunk, ctx_we, mem_re;
  logic [7:0]          b;
  logic [STREAM_W-1:0] id_cand;
  logic                cam_hit, cam_full;
  logic [SW-1:0]       cam_slot;
  ctx_t                mem_rdata;

  assign b         = in_tdata;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !halted_r && (phase_r != PH_LOOKUP) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign lk_go     = (phase_r == PH_LOOKUP) && out_free && !halted_r;
  assign cs_eff    = (csize_r == '0) ? 24'd1 : csize_r;
  assign cfg_ready = 1'b1;

  // Candidate chunk stream id from the current basic header byte.
  always_comb begin
    id_cand     = '0;
    begin_chunk = 1'b0;
    unique case (phase_r)
      PH_BASIC: begin
        id_cand     = {11'd0, b[5:0]};
        begin_chunk = acc && (b[5:1] != 5'd0);
      end
      PH_ID1: begin
        id_cand     = ID1_BASE + {9'd0, b};
        begin_chunk = acc;
      end
      PH_ID2: begin
        id_cand     = ID1_BASE + {1'b0, b, stream_r[7:0]};
        begin_chunk = acc && (hbc_r != 4'd0);
      end
      default: begin
        id_cand     = '0;
        begin_chunk = 1'b0;
      end
    endcase
  end

  assign mem_re = begin_chunk && (cam_hit || !cam_full);

  rcd_slot_cam #(.N(NUM_CONTEXTS), .SW(SW)) u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (id_cand),
    .alloc_en  (begin_chunk),
    .hit       (cam_hit),
    .full      (cam_full),
    .slot      (cam_slot)
  );

  rcd_ctx_mem #(.N(NUM_CONTEXTS), .SW(SW)) u_mem (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (slot_r),
    .wdata (ctx_nxt),
    .re    (mem_re),
    .raddr (cam_slot),
    .rdata (mem_rdata)
  );

  always_comb begin
    ctx_t  w;
    step_t st;
    logic  last;
    phase_nxt  = phase_r;
    hbc_nxt    = hbc_r;
    fmt_nxt    = fmt_r;
    stream_nxt = stream_r;
    slot_nxt   = slot_r;
    new_nxt    = new_r;
    cbl_nxt    = cbl_r;
    ext_nxt    = ext_r;
    halted_nxt = halted_r;
    ctx_nxt    = ctx_r;
    ctx_we     = 1'b0;
    w          = ctx_r;
    st         = '0;
    last       = 1'b0;
    res_valid  = 1'b0;
    res_byte   = '0;
    res_stream = stream_r;
    res_type   = '0;
    res_index  = '0;
    res_body   = '0;
    res_stamp  = '0;
    res_last   = 1'b0;
    res_status = ST_OK;

    if (begin_chunk) begin
      stream_nxt = id_cand;
      hbc_nxt    = '0;
      if (phase_r == PH_BASIC) fmt_nxt = b[7:6];
      if (!cam_hit && cam_full) begin
        // No free context: report and stop.
        res_valid  = 1'b1;
        res_stream = id_cand;
        res_status = ST_FULL;
        halted_nxt = 1'b1;
      end else begin
        slot_nxt  = cam_slot;
        new_nxt   = !cam_hit;
        phase_nxt = PH_LOOKUP;
      end
    end else if (acc) begin
      unique case (phase_r)
        PH_BASIC: begin
          fmt_nxt   = b[7:6];
          hbc_nxt   = '0;
          phase_nxt = (b[5:0] == 6'd0) ? PH_ID1 : PH_ID2;
        end
        PH_ID2: begin
          stream_nxt = {9'd0, b};
          hbc_nxt    = 4'd1;
        end
        PH_MSGHDR: begin
          case (hbc_r)
            4'd0: w.stamp_field[23:16] = b;
            4'd1: w.stamp_field[15:8]  = b;
            4'd2: w.stamp_field[7:0]   = b;
            4'd3: w.msg_len[23:16]     = b;
            4'd4: w.msg_len[15:8]      = b;
            4'd5: w.msg_len[7:0]       = b;
            4'd6: w.msg_type           = b;
            4'd7: w.msg_index[7:0]     = b;
            4'd8: w.msg_index[15:8]    = b;
            4'd9: w.msg_index[23:16]   = b;
            4'd10: w.msg_index[31:24]  = b;
            default: w = ctx_r;
          endcase
          hbc_nxt = 4'(hbc_r + 4'd1);
          ctx_we  = 1'b1;
          ctx_nxt = w;
          if (hbc_nxt == msg_hdr_len(fmt_r)) begin
            hbc_nxt = '0;
            st      = after_msg(w, cs_eff);
            if (st.err) begin
              res_valid  = 1'b1;
              res_status = ST_BODY;
              halted_nxt = 1'b1;
            end
            ctx_nxt   = st.ctx;
            phase_nxt = st.phase;
            cbl_nxt   = st.cbl;
            ext_nxt   = st.ext;
          end
        end
        PH_EXTTS: begin
          ext_nxt = {ext_r[23:0], b};
          hbc_nxt = 4'(hbc_r + 4'd1);
          if (hbc_r == 4'd3) begin
            hbc_nxt = '0;
            st      = after_ext(ctx_r, ext_nxt, cs_eff);
            if (st.err) begin
              res_valid  = 1'b1;
              res_status = ST_BODY;
              halted_nxt = 1'b1;
            end
            ctx_we    = 1'b1;
            ctx_nxt   = st.ctx;
            phase_nxt = st.phase;
            cbl_nxt   = st.cbl;
          end
        end
        PH_PAYLOAD: begin
          w.received = ctx_r.received + 24'd1;
          cbl_nxt    = cbl_r - 24'd1;
          last       = (w.received == ctx_r.msg_len);
          res_valid  = 1'b1;
          res_byte   = b;
          res_type   = ctx_r.msg_type;
          res_index  = ctx_r.msg_index;
          res_body   = ctx_r.msg_len;
          res_last   = last;
          if (last) begin
            w.stamp_time = ext_r + (ctx_r.absolute ? 32'd0 : ctx_r.stamp_time);
            w.received   = '0;
            res_stamp    = w.stamp_time;
            phase_nxt    = PH_BASIC;
          end else if (cbl_nxt == '0) begin
            phase_nxt = PH_BASIC;
          end
          ctx_we  = 1'b1;
          ctx_nxt = w;
        end
        default: begin
          phase_nxt = PH_BASIC;
        end
      endcase
    end else if (lk_go) begin
      // Context arrives from memory; a new stream starts from zero.
      w = new_r ? '0 : mem_rdata;
      if (w.received == '0) w.absolute = 1'b0;
      if (fmt_r == 2'd0) w.absolute = 1'b1;
      ctx_we  = 1'b1;
      ctx_nxt = w;
      if (msg_hdr_len(fmt_r) != 4'd0) begin
        phase_nxt = PH_MSGHDR;
      end else begin
        st = after_msg(w, cs_eff);
        if (st.err) begin
          res_valid  = 1'b1;
          res_status = ST_BODY;
          halted_nxt = 1'b1;
        end
        ctx_nxt   = st.ctx;
        phase_nxt = st.phase;
        cbl_nxt   = st.cbl;
        ext_nxt   = st.ext;
      end
    end

    // Error results carry only the stream id and status.
    if (res_status != ST_OK) begin
      res_byte  = '0;
      res_type  = '0;
      res_index = '0;
      res_body  = '0;
      res_stamp = '0;
      res_last  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BASIC;
      hbc_r    <= '0;
      fmt_r    <= '0;
      stream_r <= '0;
      slot_r   <= '0;
      new_r    <= 1'b0;
      cbl_r    <= '0;
      ext_r    <= '0;
      halted_r <= 1'b0;
      csize_r  <= CHUNK_SIZE_RESET;
    end else begin
      phase_r  <= phase_nxt;
      hbc_r    <= hbc_nxt;
      fmt_r    <= fmt_nxt;
      stream_r <= stream_nxt;
      slot_r   <= slot_nxt;
      new_r    <= new_nxt;
      cbl_r    <= cbl_nxt;
      ext_r    <= ext_nxt;
      halted_r <= halted_nxt;
      if (cfg_valid) csize_r <= cfg_data;
    end
  end

  // Working copy of the current context; the memory is written through.
  always_ff @(posedge clk) begin
    ctx_r <= ctx_nxt;
  end

  // Output register: load a new result, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {7'd0, res_stamp, res_body, res_index, res_type, res_stream, res_byte};
      out_last_r <= res_last;
      out_user_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `RCD_ASSERT(a_no_rw_clash, clk, rst_n, !(ctx_we && mem_re), "context read and write collide")
  `RCD_ASSERT(a_halt_blocks, clk, rst_n, !(halted_r && in_tready), "input taken while halted")
  `RCD_ASSERT_NEXT(a_halt_sticks, clk, rst_n, halted_r, halted_r, "halt released before reset")
  `RCD_ASSERT(a_no_overrun, clk, rst_n, !(res_valid && !out_free), "result overwrote output")

endmodule

### rtl/rcd_slot_cam.sv
// Chunk stream id match table: valid bits and ids in flops, parallel compare.
// Depends on rcd_pkg.
`timescale 1ns / 1ps

module rcd_slot_cam
  import rcd_pkg::*;
#(
  parameter int N  = 8,
  parameter int SW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [STREAM_W-1:0] lookup_id,
  input  logic                alloc_en,
  output logic                hit,
  output logic                full,
  output logic [SW-1:0]       slot
);

  logic [N-1:0]        valid_r;
  logic [STREAM_W-1:0] id_r [N];
  logic [N-1:0]        hit_vec;
  logic [SW-1:0]       hit_slot;
  logic [SW-1:0]       free_slot;

  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      hit_vec[i] = valid_r[i] && (id_r[i] == lookup_id);
      if (hit_vec[i]) hit_slot = SW'(i);
      if (!valid_r[i]) free_slot = SW'(i);
    end
  end

  assign hit  = |hit_vec;
  assign full = &valid_r;
  assign slot = hit ? hit_slot : free_slot;

  // Claim the lowest free entry for a new stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (alloc_en && !hit && !full) begin
      valid_r[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_en && !hit && !full) begin
      id_r[free_slot] <= lookup_id;
    end
  end

endmodule

### rtl/rcd_ctx_mem.sv
// Context memory: one write port, one read port, registered read data.
// Depends on rcd_pkg for the context record.
`timescale 1ns / 1ps

module rcd_ctx_mem
  import rcd_pkg::*;
#(
  parameter int N  = 8,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  ctx_t          wdata,
  input  logic          re,
  input  logic [SW-1:0] raddr,
  output ctx_t          rdata
);

  ctx_t mem [N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
